@@ rtl/sle_pkg.sv @@
// Shared types and constants for the serial line editor.
`default_nettype none
package sle_pkg;

  localparam int BYTE_W  = 8;
  localparam int COUNT_W = 6;

  localparam logic [BYTE_W-1:0] CHAR_BS = 8'h08;
  localparam logic [BYTE_W-1:0] CHAR_SP = 8'h20;
  localparam logic [BYTE_W-1:0] CHAR_CR = 8'h0D;
  localparam logic [BYTE_W-1:0] CHAR_LF = 8'h0A;

  localparam logic [COUNT_W-1:0] MAX_LEN_RESET = 6'd32;

  typedef enum logic [1:0] {
    KIND_ECHO = 2'd0,
    KIND_LINE = 2'd1,
    KIND_END  = 2'd2
  } kind_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic  accept;     // take the input byte and update the line
    logic  echo_clr;
    logic  echo_inc;
    logic  rd_clr;
    logic  rd_inc;
    logic  rd_en;      // read the line store at the walk index
    logic  out_load;   // load the output register
    kind_t out_kind;
    logic  count_clr;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic               in_drop;     // byte causes no result
    logic               echo_last;   // current echo byte is the final one
    logic               finish;      // the line ends after the echo
    logic               count_zero;
    logic               rd_last;     // current line byte is the final one
    logic               slot_free;   // output register can take an item
    logic [COUNT_W-1:0] count;
  } sts_t;

endpackage
`default_nettype wire

@@ rtl/serial_line_editor_unit.sv @@
// Top level of the serial line editor: controller, datapath and port packing.
//
//  channel   direction  signals                       contents
//  cfg       in         cfg_wr_en, cfg_wr_data        max_line_length
//  s         in         s_tvalid/tready/tdata         received byte
//  m         out        m_tvalid/tready/tdata/tuser   echo byte, line byte or line end
//                       m_tlast                       final result of one input byte
//
// An input byte is taken while the controller is idle; each echo item then waits for a free output register.
// A line end walks the line store with a registered RAM read, then an output load, for each
// stored byte, and then loads the end item.
// A result waits in the output register while the next byte can already be taken.
// Stalls on m hold the sequence in place; rst clears the count and sets the maximum to 32.
`default_nettype none
module serial_line_editor_unit #(
  parameter int LINE_MAX = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wr_en,
  input  wire logic [5:0]  cfg_wr_data,  // max_line_length
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,      // [7:0] rx_byte
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [15:0] m_tdata,      // [7:0] data_byte, [13:8] line_length, [15:14] zero
  output logic      [1:0]  m_tuser,      // [1:0] item_kind
  output logic             m_tlast       // last_of_run
);

  sle_pkg::cmd_t  cmd;
  sle_pkg::sts_t  sts;
  sle_pkg::kind_t out_kind;
  logic [sle_pkg::BYTE_W-1:0]  out_data;
  logic [sle_pkg::COUNT_W-1:0] out_len;

  sle_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  sle_datapath #(
    .LINE_MAX (LINE_MAX)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_byte     (s_tdata),
    .cmd         (cmd),
    .sts         (sts),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_kind    (out_kind),
    .out_data    (out_data),
    .out_len     (out_len),
    .out_last    (m_tlast)
  );

  assign m_tdata = {2'b00, out_len, out_data};
  assign m_tuser = out_kind;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    sts.count <= sle_pkg::COUNT_W'(LINE_MAX))
    else $error("line count exceeds the line store depth");

  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == sle_pkg::KIND_END |-> m_tlast)
    else $error("line end item without last flag");

  a_len_only_on_end: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != sle_pkg::KIND_END |-> m_tdata[13:8] == '0)
    else $error("length set on an echo or line byte item");

  a_drop_keeps_ready: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tdata == '0 |=> s_tready)
    else $error("ignored byte started a sequence");

endmodule
`default_nettype wire

@@ rtl/sle_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module sle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                            clk,
  input  wire logic                            wr_en,
  input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                wr_data,
  input  wire logic                            rd_en,
  input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

@@ rtl/sle_datapath.sv @@
// Datapath: line count, config register, echo selection, line store and output register.
`default_nettype none
module sle_datapath #(
  parameter int LINE_MAX = 32
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_wr_en,
  input  wire logic [sle_pkg::COUNT_W-1:0]    cfg_wr_data,
  input  wire logic [sle_pkg::BYTE_W-1:0]     in_byte,
  input  wire sle_pkg::cmd_t                  cmd,
  output sle_pkg::sts_t                       sts,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output sle_pkg::kind_t                      out_kind,
  output logic      [sle_pkg::BYTE_W-1:0]     out_data,
  output logic      [sle_pkg::COUNT_W-1:0]    out_len,
  output logic                                out_last
);

  localparam int AW = $clog2(LINE_MAX > 1 ? LINE_MAX : 2);
  localparam logic [sle_pkg::COUNT_W-1:0] LIMIT = sle_pkg::COUNT_W'(LINE_MAX);

  logic [sle_pkg::BYTE_W-1:0]  byte_q;
  logic [sle_pkg::COUNT_W-1:0] count;
  logic [sle_pkg::COUNT_W-1:0] max_cfg;
  logic [sle_pkg::COUNT_W-1:0] rd_idx;
  logic [1:0]                  echo_idx;
  logic [sle_pkg::COUNT_W-1:0] eff_max;
  logic [sle_pkg::BYTE_W-1:0]  echo_byte;
  logic [sle_pkg::BYTE_W-1:0]  ram_rdata;
  logic                        in_bs;
  logic                        in_term;
  logic                        q_bs;
  logic                        q_cr;
  logic                        q_term;
  logic                        store_wr;

  assign in_bs   = (in_byte == sle_pkg::CHAR_BS);
  assign in_term = (in_byte == sle_pkg::CHAR_CR) || (in_byte == sle_pkg::CHAR_LF);
  assign q_bs    = (byte_q == sle_pkg::CHAR_BS);
  assign q_cr    = (byte_q == sle_pkg::CHAR_CR);
  assign q_term  = q_cr || (byte_q == sle_pkg::CHAR_LF);

  // A stored byte is dropped once the line store is full.
  assign store_wr = cmd.accept && !in_bs && !in_term && (count < LIMIT);

  always_comb begin
    eff_max = max_cfg;
    if (max_cfg == '0) begin
      eff_max = sle_pkg::COUNT_W'(1);
    end else if (max_cfg > LIMIT) begin
      eff_max = LIMIT;
    end
  end

  // Backspace echoes BS, SP, BS; carriage return echoes LF then CR.
  always_comb begin
    echo_byte = byte_q;
    if (q_bs && echo_idx == 2'd1) begin
      echo_byte = sle_pkg::CHAR_SP;
    end else if (q_cr && echo_idx == 2'd0) begin
      echo_byte = sle_pkg::CHAR_LF;
    end
  end

  always_comb begin
    sts.in_drop    = (in_byte == '0) || in_byte[sle_pkg::BYTE_W-1] ||
                     (in_bs && count == '0);
    sts.echo_last  = q_bs ? (echo_idx == 2'd2) : (q_cr ? (echo_idx == 2'd1) : 1'b1);
    sts.finish     = q_term || (count >= eff_max);
    sts.count_zero = (count == '0);
    sts.rd_last    = (sle_pkg::COUNT_W'(rd_idx + 1'b1) == count);
    sts.slot_free  = !out_valid || out_ready;
    sts.count      = count;
  end

  sle_ram #(
    .WIDTH (sle_pkg::BYTE_W),
    .DEPTH (LINE_MAX)
  ) u_store (
    .clk     (clk),
    .wr_en   (store_wr),
    .wr_addr (count[AW-1:0]),
    .wr_data (in_byte),
    .rd_en   (cmd.rd_en),
    .rd_addr (rd_idx[AW-1:0]),
    .rd_data (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      max_cfg   <= sle_pkg::MAX_LEN_RESET;
      out_valid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        max_cfg <= cfg_wr_data;
      end
      if (cmd.count_clr) begin
        count <= '0;
      end else if (cmd.accept && in_bs) begin
        count <= count - 1'b1;
      end else if (store_wr) begin
        count <= count + 1'b1;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      byte_q <= in_byte;
    end
    if (cmd.echo_clr) begin
      echo_idx <= '0;
    end else if (cmd.echo_inc) begin
      echo_idx <= echo_idx + 1'b1;
    end
    if (cmd.rd_clr) begin
      rd_idx <= '0;
    end else if (cmd.rd_inc) begin
      rd_idx <= rd_idx + 1'b1;
    end
    if (cmd.out_load) begin
      out_kind <= cmd.out_kind;
      unique case (cmd.out_kind)
        sle_pkg::KIND_ECHO: begin
          out_data <= echo_byte;
          out_len  <= '0;
          out_last <= sts.echo_last && !sts.finish;
        end
        sle_pkg::KIND_LINE: begin
          out_data <= ram_rdata;
          out_len  <= '0;
          out_last <= 1'b0;
        end
        default: begin
          out_data <= '0;
          out_len  <= count;
          out_last <= 1'b1;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

@@ rtl/sle_ctrl.sv @@
// Controller state machine: echo sequence, line walk and line end.
`default_nettype none
module sle_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire sle_pkg::sts_t sts,
  output sle_pkg::cmd_t      cmd
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_ECHO = 5'b00010,
    S_READ = 5'b00100,
    S_LINE = 5'b01000,
    S_END  = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next   = state;
    cmd          = '0;
    cmd.out_kind = sle_pkg::KIND_ECHO;
    unique case (state)
      S_IDLE: begin
        // Ignored bytes are consumed without leaving idle.
        if (in_valid && !sts.in_drop) begin
          cmd.accept   = 1'b1;
          cmd.echo_clr = 1'b1;
          state_next   = S_ECHO;
        end
      end
      S_ECHO: begin
        cmd.out_kind = sle_pkg::KIND_ECHO;
        if (sts.slot_free) begin
          cmd.out_load = 1'b1;
          if (!sts.echo_last) begin
            cmd.echo_inc = 1'b1;
          end else if (!sts.finish) begin
            state_next = S_IDLE;
          end else if (sts.count_zero) begin
            state_next = S_END;
          end else begin
            cmd.rd_clr = 1'b1;
            state_next = S_READ;
          end
        end
      end
      S_READ: begin
        cmd.rd_en  = 1'b1;
        state_next = S_LINE;
      end
      S_LINE: begin
        cmd.out_kind = sle_pkg::KIND_LINE;
        if (sts.slot_free) begin
          cmd.out_load = 1'b1;
          cmd.rd_inc   = 1'b1;
          state_next   = sts.rd_last ? S_END : S_READ;
        end
      end
      S_END: begin
        cmd.out_kind = sle_pkg::KIND_END;
        if (sts.slot_free) begin
          cmd.out_load  = 1'b1;
          cmd.count_clr = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire
